/* rtl/assert_macros.svh */
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define MBHRS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define MBHRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/mbhrs_pkg.sv */
package mbhrs_pkg;

    // Number of leading frame bytes that are kept and decoded.
    localparam int FRAME_KEEP = 6;

    // Holding register that mirrors the sampled input word.
    localparam int MIRROR_REG = 3;

    // Input opcodes.
    localparam logic [1:0] OP_RX_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_SAMPLE  = 2'd2;

    // Function codes.
    localparam logic [7:0] FUNC_READ  = 8'h03;
    localparam logic [7:0] FUNC_WRITE = 8'h06;

    // Result kinds.
    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_DRIVE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_STATION = 1'b0;
    localparam logic CFG_GAP     = 1'b1;

    // Reset value of the drive bytes.
    localparam logic [7:0] DRIVE_RESET = 8'hFF;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMIT,
        ST_LATCH,
        ST_DRIVE
    } mbhrs_state_t;

    // Strobes from the sequencer to the receive framer.
    typedef struct packed {
        logic byte_we;
        logic tick;
    } mbhrs_rx_ctl_t;

    // Status from the receive framer to the sequencer.
    typedef struct packed {
        logic [FRAME_KEEP-1:0][7:0] frame;
        logic                       frame_long;
        logic                       gap_expired;
    } mbhrs_rx_stat_t;

endpackage

/* rtl/mbhrs_rx.sv */
module mbhrs_rx
    import mbhrs_pkg::*;
#(
    parameter int BUF_BYTES = 32
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  mbhrs_rx_ctl_t  ctl,
    input  logic [7:0]     rx_byte,
    input  logic [7:0]     gap_ticks,
    output mbhrs_rx_stat_t stat
);

    localparam int BC_W = $clog2(BUF_BYTES + 1);

    logic [BC_W-1:0]            byte_count_reg;
    logic [BC_W-1:0]            byte_count_next;
    logic [7:0]                 silence_reg;
    logic [7:0]                 silence_next;
    logic [7:0]                 silence_inc;
    logic                       expired;
    logic [FRAME_KEEP-1:0][7:0] frame_reg;

    // Saturating silence count and the end-of-frame test.
    always_comb
    begin
        silence_inc = (silence_reg == 8'hFF) ? silence_reg : silence_reg + 8'd1;
        expired     = silence_inc > gap_ticks;
    end

    // Byte count and silence counter updates.
    always_comb
    begin
        byte_count_next = byte_count_reg;
        silence_next    = silence_reg;
        if (ctl.byte_we)
        begin
            if (byte_count_reg < BC_W'(BUF_BYTES))
            begin
                byte_count_next = byte_count_reg + BC_W'(1);
            end
            silence_next = 8'd0;
        end
        else if (ctl.tick)
        begin
            if (expired)
            begin
                byte_count_next = '0;
                silence_next    = 8'd0;
            end
            else
            begin
                silence_next = silence_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            silence_reg    <= 8'd0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            silence_reg    <= silence_next;
        end
    end

    // Only the leading bytes of a frame are stored.
    always_ff @(posedge clk)
    begin
        if (ctl.byte_we && (byte_count_reg < BC_W'(FRAME_KEEP)))
        begin
            frame_reg[byte_count_reg[2:0]] <= rx_byte;
        end
    end

    assign stat.frame       = frame_reg;
    assign stat.frame_long  = byte_count_reg >= BC_W'(FRAME_KEEP);
    assign stat.gap_expired = expired;

endmodule

/* rtl/mbhrs_regbank.sv */
module mbhrs_regbank
    import mbhrs_pkg::*;
#(
    parameter  int REG_COUNT = 4,
    localparam int AW        = $clog2(REG_COUNT)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0]          mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [15:0]          rd_data_reg;
    logic                 rd_valid_reg;

    // Storage array with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Entries that were never written read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : 16'd0;

endmodule

/* rtl/mbhrs_ctrl.sv */
module mbhrs_ctrl
    import mbhrs_pkg::*;
#(
    parameter  int REG_COUNT = 4,
    localparam int AW        = $clog2(REG_COUNT)
)
(
    input  logic           clk,
    input  logic           rst_n,
    // Input channel
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     opcode,
    input  logic [15:0]    input_word,
    // Configuration
    input  logic [7:0]     station_address,
    // Receive framer
    output mbhrs_rx_ctl_t  rx_ctl,
    input  mbhrs_rx_stat_t rx_stat,
    // Register bank
    output logic           wr_en,
    output logic [AW-1:0]  wr_addr,
    output logic [15:0]    wr_data,
    output logic           rd_en,
    output logic [AW-1:0]  rd_addr,
    input  logic [15:0]    rd_data,
    // Result channel
    output logic           out_valid,
    input  logic           out_ready,
    output logic           result_kind,
    output logic [7:0]     tx_byte,
    output logic           tx_last,
    output logic [7:0]     drive_high,
    output logic [7:0]     drive_low
);

    localparam int POS_W = $clog2(2 * REG_COUNT + 3);

    mbhrs_state_t state_reg;
    mbhrs_state_t state_next;

    logic             accept;
    logic [7:0]       func;
    logic [15:0]      a_word;
    logic [15:0]      v_word;
    logic             frame_go;
    logic [15:0]      opa;
    logic [15:0]      opb;
    logic [16:0]      sum;
    logic             in_range;
    logic             slot_free;
    logic             emit_last;
    logic [7:0]       emit_byte;
    logic             load_tx;
    logic             load_drive;
    logic             do_write;

    logic             is_read_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] last_pos_reg;
    logic [AW-1:0]    addr_reg;
    logic [7:0]       mirror0_reg;
    logic [7:0]       mirror1_reg;
    logic [7:0]       drive_high_reg;
    logic [7:0]       drive_low_reg;
    logic             out_valid_reg;
    logic             result_kind_reg;
    logic [7:0]       tx_byte_reg;
    logic             tx_last_reg;
    logic [7:0]       drive_high_out_reg;
    logic [7:0]       drive_low_out_reg;

    // Request fields of the held frame.
    assign accept   = in_valid && in_ready;
    assign func     = rx_stat.frame[1];
    assign a_word   = {rx_stat.frame[2], rx_stat.frame[3]};
    assign v_word   = {rx_stat.frame[4], rx_stat.frame[5]};
    assign frame_go = rx_stat.frame_long && (rx_stat.frame[0] == station_address)
                      && ((func == FUNC_READ) || (func == FUNC_WRITE));

    // Shared adder: bank range check, then the read address walk.
    always_comb
    begin
        opa = a_word;
        opb = 16'd1;
        if ((state_reg == ST_CHECK) && (func == FUNC_READ))
        begin
            opb = v_word;
        end
        if (state_reg == ST_EMIT)
        begin
            opa = {{(16 - AW){1'b0}}, addr_reg};
        end
        sum = {1'b0, opa} + {1'b0, opb};
    end

    assign in_range  = sum <= 17'(REG_COUNT);
    assign slot_free = !out_valid_reg || out_ready;
    assign emit_last = pos_reg == last_pos_reg;
    assign do_write  = (state_reg == ST_CHECK) && in_range && (func == FUNC_WRITE);

    // Response byte for the current position.
    always_comb
    begin
        if (is_read_reg)
        begin
            if (pos_reg == POS_W'(0))
            begin
                emit_byte = rx_stat.frame[0];
            end
            else if (pos_reg == POS_W'(1))
            begin
                emit_byte = rx_stat.frame[1];
            end
            else if (pos_reg == POS_W'(2))
            begin
                emit_byte = {v_word[6:0], 1'b0};
            end
            else if (pos_reg[0])
            begin
                emit_byte = rd_data[15:8];
            end
            else
            begin
                emit_byte = rd_data[7:0];
            end
        end
        else
        begin
            emit_byte = rx_stat.frame[pos_reg[2:0]];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (opcode == OP_TICK) && rx_stat.gap_expired)
                begin
                    state_next = frame_go ? ST_CHECK : ST_LATCH;
                end
                else if (accept && (opcode == OP_SAMPLE))
                begin
                    state_next = ST_DRIVE;
                end
            end
            ST_CHECK:
            begin
                state_next = in_range ? ST_EMIT : ST_LATCH;
            end
            ST_EMIT:
            begin
                if (slot_free && emit_last)
                begin
                    state_next = ST_LATCH;
                end
            end
            ST_LATCH:
            begin
                state_next = ST_IDLE;
            end
            ST_DRIVE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready       = 1'b0;
        rx_ctl.byte_we = 1'b0;
        rx_ctl.tick    = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = a_word[AW-1:0];
        wr_data        = v_word;
        rd_en          = 1'b0;
        rd_addr        = a_word[AW-1:0];
        load_tx        = 1'b0;
        load_drive     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                rx_ctl.byte_we = accept && (opcode == OP_RX_BYTE);
                rx_ctl.tick    = accept && (opcode == OP_TICK);
                if (accept && (opcode == OP_SAMPLE))
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(MIRROR_REG);
                    wr_data = input_word;
                end
            end
            ST_CHECK:
            begin
                wr_en = do_write;
                rd_en = in_range && (func == FUNC_READ) && (v_word != 16'd0);
            end
            ST_EMIT:
            begin
                load_tx = slot_free;
                // Fetch the next word while its predecessor's low byte moves out.
                if (slot_free && is_read_reg && !emit_last && !pos_reg[0]
                    && (pos_reg >= POS_W'(4)))
                begin
                    rd_en   = 1'b1;
                    rd_addr = sum[AW-1:0];
                end
            end
            ST_LATCH:
            begin
            end
            ST_DRIVE:
            begin
                load_drive = slot_free;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            is_read_reg    <= 1'b0;
            pos_reg        <= '0;
            last_pos_reg   <= '0;
            addr_reg       <= '0;
            mirror0_reg    <= 8'd0;
            mirror1_reg    <= 8'd0;
            drive_high_reg <= DRIVE_RESET;
            drive_low_reg  <= DRIVE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CHECK)
            begin
                is_read_reg <= func == FUNC_READ;
                pos_reg     <= '0;
                addr_reg    <= a_word[AW-1:0];
                if (func == FUNC_READ)
                begin
                    last_pos_reg <= {v_word[POS_W-2:0], 1'b0} + POS_W'(2);
                end
                else
                begin
                    last_pos_reg <= POS_W'(FRAME_KEEP - 1);
                end
            end
            if (load_tx)
            begin
                pos_reg <= pos_reg + POS_W'(1);
            end
            if (rd_en && (state_reg == ST_EMIT))
            begin
                addr_reg <= sum[AW-1:0];
            end
            // Low bytes of registers 0 and 1 are kept for the drive latch.
            if (do_write && (a_word == 16'd0))
            begin
                mirror0_reg <= v_word[7:0];
            end
            if (do_write && (a_word == 16'd1))
            begin
                mirror1_reg <= v_word[7:0];
            end
            if (state_reg == ST_LATCH)
            begin
                drive_high_reg <= mirror0_reg;
                drive_low_reg  <= mirror1_reg;
            end
            if (load_tx || load_drive)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load_tx)
        begin
            result_kind_reg    <= KIND_TX;
            tx_byte_reg        <= emit_byte;
            tx_last_reg        <= emit_last;
            drive_high_out_reg <= 8'd0;
            drive_low_out_reg  <= 8'd0;
        end
        else if (load_drive)
        begin
            result_kind_reg    <= KIND_DRIVE;
            tx_byte_reg        <= 8'd0;
            tx_last_reg        <= 1'b0;
            drive_high_out_reg <= drive_high_reg;
            drive_low_out_reg  <= drive_low_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = result_kind_reg;
    assign tx_byte     = tx_byte_reg;
    assign tx_last     = tx_last_reg;
    assign drive_high  = drive_high_out_reg;
    assign drive_low   = drive_low_out_reg;

endmodule

/* rtl/modbus_holding_register_slave_core.sv */
// Channel   Handshake               Payload
// cfg       cfg_we                  cfg_index, cfg_data
// input     in_valid / in_ready     opcode, rx_byte, input_word
// result    out_valid / out_ready   result_kind, tx_byte, tx_last, drive_high, drive_low
//
// A tick that ends a frame goes through check, unless the frame is ignored, and latch.
// A read of n words and a write echo go out one byte per cycle while the result channel
// does not stall, through the output register, the bank's single read port fetching
// one word per two bytes. Reset clears control state at once; there is no clearing
// pass. A stalled result channel holds the sequencer, and no input is taken until the
// response is queued.
module modbus_holding_register_slave_core
    import mbhrs_pkg::*;
#(
    parameter int REG_COUNT = 4,
    parameter int BUF_BYTES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] input_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [7:0]  tx_byte,
    output logic        tx_last,
    output logic [7:0]  drive_high,
    output logic [7:0]  drive_low
);

    localparam int AW = $clog2(REG_COUNT);

    logic [7:0]     station_reg;
    logic [7:0]     gap_reg;
    mbhrs_rx_ctl_t  rx_ctl;
    mbhrs_rx_stat_t rx_stat;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [15:0]    wr_data;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [15:0]    rd_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg <= 8'd1;
            gap_reg     <= 8'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STATION: station_reg <= cfg_data;
                CFG_GAP:     gap_reg     <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Frame capture and silence timing.
    mbhrs_rx #(
        .BUF_BYTES (BUF_BYTES)
    ) u_rx (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (rx_ctl),
        .rx_byte   (rx_byte),
        .gap_ticks (gap_reg),
        .stat      (rx_stat)
    );

    // Holding register storage.
    mbhrs_regbank #(
        .REG_COUNT (REG_COUNT)
    ) u_regbank (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Request sequencer and result register.
    mbhrs_ctrl #(
        .REG_COUNT (REG_COUNT)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .input_word      (input_word),
        .station_address (station_reg),
        .rx_ctl          (rx_ctl),
        .rx_stat         (rx_stat),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .tx_byte         (tx_byte),
        .tx_last         (tx_last),
        .drive_high      (drive_high),
        .drive_low       (drive_low)
    );

endmodule

/* rtl/mbhrs_checker.sv */
`include "assert_macros.svh"

module mbhrs_checker
    import mbhrs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        result_kind,
    input logic [7:0]  tx_byte,
    input logic        tx_last,
    input logic [7:0]  drive_high,
    input logic [7:0]  drive_low
);

    // A drive result carries no response byte.
    `MBHRS_ASSERT(a_drive_clean, clk, rst_n, (out_valid && (result_kind == KIND_DRIVE)) |-> ((tx_byte == 8'd0) && !tx_last), "drive result with response byte fields set")

    // A response byte carries no drive bytes.
    `MBHRS_ASSERT(a_tx_clean, clk, rst_n, (out_valid && (result_kind == KIND_TX)) |-> ((drive_high == 8'd0) && (drive_low == 8'd0)), "response byte with drive fields set")

    // While a response is still going out, no new input is taken.
    `MBHRS_ASSERT(a_busy_in_burst, clk, rst_n, (out_valid && out_ready && (result_kind == KIND_TX) && !tx_last) |=> !in_ready, "input taken in the middle of a response")

    // A result that is not taken stays with the same payload.
    `MBHRS_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(tx_byte) && $stable(result_kind) && $stable(tx_last)), "stalled result changed")

endmodule

bind modbus_holding_register_slave_core mbhrs_checker u_mbhrs_checker (.*);
